### design/yft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yft_pkg
// Shared sizes, types and helpers of the Yee field trilinear gather block.
// ----------------------------------------------------------------------------
package yft_pkg;

  localparam int GRID_X    = 16;
  localparam int GRID_Y    = 16;
  localparam int GRID_Z    = 16;
  localparam int FRAC_BITS = 16;

  localparam int CELLS   = GRID_X * GRID_Y * GRID_Z;
  localparam int AW      = $clog2(CELLS);
  localparam int XW      = $clog2(GRID_X);
  localparam int YW      = $clog2(GRID_Y);
  localparam int ZW      = $clog2(GRID_Z);
  localparam int NCOMP   = 6;
  localparam int NCORNER = 8;
  localparam int ACC_W   = 34;
  localparam int PROD_W  = 34 + FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_LOAD,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } yft_state_e;

  typedef enum logic [1:0] {
    CFG_ORIGIN_X,
    CFG_ORIGIN_Y,
    CFG_ORIGIN_Z
  } cfg_reg_e;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       add;
    logic [2:0] widx;
  } lerp_ctrl_t;

  function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x,
                                            input logic [YW-1:0] y,
                                            input logic [ZW-1:0] z);
    logic [AW-1:0] xy;
    xy = AW'(x) * AW'(GRID_Y) + AW'(y);
    return xy * AW'(GRID_Z) + AW'(z);
  endfunction

  // axes over which a component is averaged, bit 0 = x, 1 = y, 2 = z
  function automatic logic [2:0] avg_mask(input int n);
    logic [2:0] m;
    case (n)
      0:       m = 3'b001;
      1:       m = 3'b010;
      2:       m = 3'b100;
      3:       m = 3'b110;
      4:       m = 3'b101;
      default: m = 3'b011;
    endcase
    return m;
  endfunction

  // does the cell at offset o (0..2 = -1..+1) feed corner k = {c,b,a}
  function automatic logic acc_hit(input int n, input int k,
                                   input logic [1:0] ox, input logic [1:0] oy,
                                   input logic [1:0] oz);
    logic [2:0] m;
    logic [1:0] ca, cb, cc;
    logic       hx, hy, hz;
    m  = avg_mask(n);
    ca = (k % 2 == 1) ? 2'd1 : 2'd0;
    cb = ((k / 2) % 2 == 1) ? 2'd1 : 2'd0;
    cc = ((k / 4) % 2 == 1) ? 2'd1 : 2'd0;
    hx = (ox == ca + 2'd1) || (m[0] && ox == ca);
    hy = (oy == cb + 2'd1) || (m[1] && oy == cb);
    hz = (oz == cc + 2'd1) || (m[2] && oz == cc);
    return hx && hy && hz;
  endfunction

endpackage

### design/yee_field_trilinear_gather.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yee_field_trilinear_gather
// Yee lattice field store with trilinear field gather at particle positions.
// ----------------------------------------------------------------------------
// Usage:
//   Config channel (cfg_valid_i/cfg_ready_o, always ready) writes origin_x,
//   origin_y, origin_z at index 0..2; other indexes are ignored.
//   Input requests (in_valid_i/in_stall_o): kind 0 writes the six field
//   components of the cell at the integer part of pos and gives no
//   result. Kind 1 queries the fields at pos.
//   A query reads its 3x3x3 cell neighbourhood through the single port of
//   the six field memories, one cell per cycle, loads the corner means,
//   then runs seven lerp steps, each a multiply then an add, on six
//   parallel multiplier lanes. An out-of-grid query returns out_of_range
//   with zero fields.
//   Results (out_valid_o/out_stall_i) sit in an output register; a new
//   request is taken while a result waits, and a finished query holds until
//   the register frees up. in_stall_o is high while a query is in flight.
//   Reset clears the origin and control; field memories are undefined until
//   written.
// ----------------------------------------------------------------------------
module yee_field_trilinear_gather (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] e_x_i,
  input  logic signed [31:0] e_y_i,
  input  logic signed [31:0] e_z_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               out_of_range_o,
  output logic signed [31:0] ipo_e_x_o,
  output logic signed [31:0] ipo_e_y_o,
  output logic signed [31:0] ipo_e_z_o,
  output logic signed [31:0] ipo_b_x_o,
  output logic signed [31:0] ipo_b_y_o,
  output logic signed [31:0] ipo_b_z_o
);

  localparam int FB = yft_pkg::FRAC_BITS;

  yft_pkg::yft_state_e state_q, state_d;

  logic signed [31:0]          origin_q [3];
  logic [yft_pkg::XW-1:0]      cx_q;
  logic [yft_pkg::YW-1:0]      cy_q;
  logic [yft_pkg::ZW-1:0]      cz_q;
  logic [FB-1:0]               fx_q, fy_q, fz_q;
  logic                        qoor_q;
  logic [1:0]                  ox_q, oy_q, oz_q, ox_d, oy_d, oz_d;
  logic [1:0]                  rox_q, roy_q, roz_q;
  logic                        rvld_q, rvld_d;
  logic [2:0]                  st_q, st_d;
  logic                        out_valid_q;
  logic                        oor_out_q;
  logic signed [31:0]          res_q [yft_pkg::NCOMP];
  logic signed [yft_pkg::ACC_W-1:0] acc_q [yft_pkg::NCOMP][yft_pkg::NCORNER];

  logic                        in_acc, out_acc, out_load, q_start;
  logic signed [33:0]          wcx, wcy, wcz, dx, dy, dz, qcx, qcy, qcz;
  logic                        w_in, q_in;
  logic [yft_pkg::XW-1:0]      rx;
  logic [yft_pkg::YW-1:0]      ry;
  logic [yft_pkg::ZW-1:0]      rz;
  logic [yft_pkg::AW-1:0]      mem_addr;
  logic                        mem_we;
  logic [31:0]                 wdata [yft_pkg::NCOMP];
  logic [31:0]                 rdata [yft_pkg::NCOMP];
  logic signed [31:0]          lane_res [yft_pkg::NCOMP];
  logic [FB-1:0]               frac;
  yft_pkg::lerp_ctrl_t         lctrl;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != yft_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;

  // write cell index and query cell, both in 34-bit signed
  assign wcx = 34'(pos_x_i) >>> FB;
  assign wcy = 34'(pos_y_i) >>> FB;
  assign wcz = 34'(pos_z_i) >>> FB;
  assign dx  = 34'(pos_x_i) - 34'(origin_q[0]);
  assign dy  = 34'(pos_y_i) - 34'(origin_q[1]);
  assign dz  = 34'(pos_z_i) - 34'(origin_q[2]);
  assign qcx = dx >>> FB;
  assign qcy = dy >>> FB;
  assign qcz = dz >>> FB;

  assign w_in = wcx >= 34'sd0 && wcx < 34'(yft_pkg::GRID_X) &&
                wcy >= 34'sd0 && wcy < 34'(yft_pkg::GRID_Y) &&
                wcz >= 34'sd0 && wcz < 34'(yft_pkg::GRID_Z);
  assign q_in = qcx >= 34'sd1 && qcx <= 34'(yft_pkg::GRID_X - 2) &&
                qcy >= 34'sd1 && qcy <= 34'(yft_pkg::GRID_Y - 2) &&
                qcz >= 34'sd1 && qcz <= 34'(yft_pkg::GRID_Z - 2);

  assign q_start = in_acc && kind_i && q_in;

  assign rx = cx_q + yft_pkg::XW'(ox_q) - yft_pkg::XW'(1);
  assign ry = cy_q + yft_pkg::YW'(oy_q) - yft_pkg::YW'(1);
  assign rz = cz_q + yft_pkg::ZW'(oz_q) - yft_pkg::ZW'(1);

  assign mem_we   = in_acc && !kind_i && w_in;
  assign mem_addr = (state_q == yft_pkg::ST_READ) ? yft_pkg::addr_of(rx, ry, rz) :
                    yft_pkg::addr_of(wcx[yft_pkg::XW-1:0], wcy[yft_pkg::YW-1:0],
                                     wcz[yft_pkg::ZW-1:0]);

  assign wdata[0] = e_x_i;
  assign wdata[1] = e_y_i;
  assign wdata[2] = e_z_i;
  assign wdata[3] = b_x_i;
  assign wdata[4] = b_y_i;
  assign wdata[5] = b_z_i;

  for (genvar n = 0; n < yft_pkg::NCOMP; n++) begin : g_comp
    logic signed [31:0] mean [yft_pkg::NCORNER];

    yft_ram #(
      .ADDR_W (yft_pkg::AW),
      .DATA_W (32),
      .DEPTH  (yft_pkg::CELLS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (mem_we),
      .addr_i  (mem_addr),
      .wdata_i (wdata[n]),
      .rdata_o (rdata[n])
    );

    for (genvar k = 0; k < yft_pkg::NCORNER; k++) begin : g_mean
      if (n < 3) begin : g_e
        assign mean[k] = 32'(acc_q[n][k] >>> 1);
      end else begin : g_b
        assign mean[k] = 32'(acc_q[n][k] >>> 2);
      end
    end

    yft_lerp u_lerp (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lctrl),
      .mean_i (mean),
      .frac_i (frac),
      .res_o  (lane_res[n])
    );
  end

  // corner sums, laid out {c,b,a} so lerp pairs sit next to each other
  always_ff @(posedge clk_i) begin
    for (int n = 0; n < yft_pkg::NCOMP; n++) begin
      for (int k = 0; k < yft_pkg::NCORNER; k++) begin
        if (q_start) begin
          acc_q[n][k] <= '0;
        end else if (rvld_q && yft_pkg::acc_hit(n, k, rox_q, roy_q, roz_q)) begin
          acc_q[n][k] <= acc_q[n][k] + yft_pkg::ACC_W'($signed(rdata[n]));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && kind_i) begin
      cx_q   <= qcx[yft_pkg::XW-1:0];
      cy_q   <= qcy[yft_pkg::YW-1:0];
      cz_q   <= qcz[yft_pkg::ZW-1:0];
      fx_q   <= dx[FB-1:0];
      fy_q   <= dy[FB-1:0];
      fz_q   <= dz[FB-1:0];
      qoor_q <= !q_in;
    end
    rox_q <= ox_q;
    roy_q <= oy_q;
    roz_q <= oz_q;
    if (out_load) begin
      oor_out_q <= qoor_q;
      for (int n = 0; n < yft_pkg::NCOMP; n++) begin
        res_q[n] <= qoor_q ? 32'sd0 : lane_res[n];
      end
    end
  end

  always_comb begin
    if (st_q < 3'd4) begin
      frac = fx_q;
    end else if (st_q < 3'd6) begin
      frac = fy_q;
    end else begin
      frac = fz_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    ox_d       = ox_q;
    oy_d       = oy_q;
    oz_d       = oz_q;
    st_d       = st_q;
    rvld_d     = 1'b0;
    out_load   = 1'b0;
    lctrl      = '0;
    lctrl.widx = 3'd6 - st_q;
    case (state_q)
      yft_pkg::ST_IDLE: begin
        if (in_acc && kind_i) begin
          ox_d = 2'd0;
          oy_d = 2'd0;
          oz_d = 2'd0;
          state_d = q_in ? yft_pkg::ST_READ : yft_pkg::ST_OUT;
        end
      end
      yft_pkg::ST_READ: begin
        rvld_d = 1'b1;
        if (oz_q != 2'd2) begin
          oz_d = oz_q + 2'd1;
        end else begin
          oz_d = 2'd0;
          if (oy_q != 2'd2) begin
            oy_d = oy_q + 2'd1;
          end else begin
            oy_d = 2'd0;
            ox_d = ox_q + 2'd1;
            if (ox_q == 2'd2) begin
              state_d = yft_pkg::ST_DRAIN;
            end
          end
        end
      end
      yft_pkg::ST_DRAIN: begin
        state_d = yft_pkg::ST_LOAD;
      end
      yft_pkg::ST_LOAD: begin
        lctrl.load = 1'b1;
        st_d       = 3'd0;
        state_d    = yft_pkg::ST_MUL;
      end
      yft_pkg::ST_MUL: begin
        lctrl.mul = 1'b1;
        state_d   = yft_pkg::ST_ADD;
      end
      yft_pkg::ST_ADD: begin
        lctrl.add = 1'b1;
        st_d      = st_q + 3'd1;
        state_d   = (st_q == 3'd6) ? yft_pkg::ST_OUT : yft_pkg::ST_MUL;
      end
      yft_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = yft_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = yft_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= yft_pkg::ST_IDLE;
      ox_q        <= 2'd0;
      oy_q        <= 2'd0;
      oz_q        <= 2'd0;
      st_q        <= 3'd0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
      origin_q[0] <= 32'sd0;
      origin_q[1] <= 32'sd0;
      origin_q[2] <= 32'sd0;
    end else begin
      state_q <= state_d;
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      oz_q    <= oz_d;
      st_q    <= st_d;
      rvld_q  <= rvld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (yft_pkg::cfg_reg_e'(cfg_index_i))
          yft_pkg::CFG_ORIGIN_X: origin_q[0] <= cfg_data_i;
          yft_pkg::CFG_ORIGIN_Y: origin_q[1] <= cfg_data_i;
          yft_pkg::CFG_ORIGIN_Z: origin_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_of_range_o = oor_out_q;
  assign ipo_e_x_o      = res_q[0];
  assign ipo_e_y_o      = res_q[1];
  assign ipo_e_z_o      = res_q[2];
  assign ipo_b_x_o      = res_q[3];
  assign ipo_b_y_o      = res_q[4];
  assign ipo_b_z_o      = res_q[5];

  a_rvld_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvld_q |-> (state_q == yft_pkg::ST_READ || state_q == yft_pkg::ST_DRAIN))
    else $error("read data outside gather");
  a_load_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == yft_pkg::ST_LOAD |-> $past(state_q) == yft_pkg::ST_DRAIN)
    else $error("corner load before last read");
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |->
      (ipo_e_x_o == 32'sd0 && ipo_e_y_o == 32'sd0 && ipo_e_z_o == 32'sd0 &&
       ipo_b_x_o == 32'sd0 && ipo_b_y_o == 32'sd0 && ipo_b_z_o == 32'sd0))
    else $error("out-of-range result with nonzero field");
  a_rose_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == yft_pkg::ST_OUT)
    else $error("result without finished query");

endmodule

### design/yft_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yft_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module yft_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 32,
  parameter int DEPTH  = 4096
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### design/yft_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yft_lerp
// One component lane: eight corner means in a queue, reduced by seven lerps.
// ----------------------------------------------------------------------------
module yft_lerp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  yft_pkg::lerp_ctrl_t           ctrl_i,
  input  logic signed [31:0]            mean_i [yft_pkg::NCORNER],
  input  logic [yft_pkg::FRAC_BITS-1:0] frac_i,
  output logic signed [31:0]            res_o
);

  logic signed [31:0]                 q_q [yft_pkg::NCORNER];
  logic signed [31:0]                 a_q;
  logic signed [yft_pkg::PROD_W-1:0]  prod_q;
  logic signed [32:0]                 diff;
  logic signed [33:0]                 sum;
  logic                               busy_q;

  assign diff = {q_q[1][31], q_q[1]} - {q_q[0][31], q_q[0]};
  assign sum  = {{2{a_q[31]}}, a_q} + prod_q[yft_pkg::FRAC_BITS +: 34];

  // pairs sit at the head; each lerp pops two and writes its result behind
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      q_q <= mean_i;
    end else begin
      if (ctrl_i.mul) begin
        for (int i = 0; i < yft_pkg::NCORNER - 2; i++) begin
          q_q[i] <= q_q[i+2];
        end
        a_q    <= q_q[0];
        prod_q <= yft_pkg::PROD_W'(diff) * yft_pkg::PROD_W'($signed({1'b0, frac_i}));
      end
      if (ctrl_i.add) begin
        q_q[ctrl_i.widx] <= sum[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (ctrl_i.load || ctrl_i.mul) begin
      busy_q <= 1'b1;
    end else if (ctrl_i.add && ctrl_i.widx == 3'd0) begin
      busy_q <= 1'b0;
    end
  end

  assign res_o = q_q[0];

  a_add_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.add |-> $past(ctrl_i.mul)) else $error("lerp add without product");
  a_no_mul_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.mul && ctrl_i.add)) else $error("lerp mul and add together");
  a_busy_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.mul |-> busy_q) else $error("lerp step without loaded queue");

endmodule
